>>> design/rpr_pkg.sv
// Shared types, constants and the arctangent table of the rotary position rotator.
// Used by rpr_front, rpr_cell, rpr_back and rotary_position_rotator_unit; depends on nothing.
package rpr_pkg;

	// Sizes
	localparam int PAIRS         = 64;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int PAIR_W        = 6;
	localparam int TABLE_DEPTH   = 2 ** PAIR_W;
	localparam int POS_W         = 12;
	localparam int FREQ_W        = 32;
	localparam int DATA_W        = 16;
	localparam int STAGE_W       = $clog2(ATAN_ENTRIES);
	localparam int CW            = 33;   // x and y, scale 2^30
	localparam int ZW            = 33;   // residual angle, 2^-32 turn

	localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

	// Item codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_ROTATE = 1'b1;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	typedef struct packed {
		logic                      func;
		logic [PAIR_W-1:0]         pair_index;
		logic [POS_W-1:0]          position;
		logic [FREQ_W-1:0]         freq_word;
		logic signed [DATA_W-1:0]  q_even;
		logic signed [DATA_W-1:0]  q_odd;
		logic signed [DATA_W-1:0]  k_even;
		logic signed [DATA_W-1:0]  k_odd;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  q_even_out;
		logic signed [DATA_W-1:0]  q_odd_out;
		logic signed [DATA_W-1:0]  k_even_out;
		logic signed [DATA_W-1:0]  k_odd_out;
		logic                      saturated;
	} out_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  q_even;
		logic signed [DATA_W-1:0]  q_odd;
		logic signed [DATA_W-1:0]  k_even;
		logic signed [DATA_W-1:0]  k_odd;
	} vec_t;

	// What travels along the CORDIC row
	typedef struct packed {
		quad_t                 quad;
		vec_t                  vec;
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [ZW-1:0]  z;
	} rot_t;

	// atan(2^-i) in units of 2^-32 turn, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_turns(input logic [STAGE_W-1:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:    a = ZW'(536870912);
			5'd1:    a = ZW'(316933406);
			5'd2:    a = ZW'(167458907);
			5'd3:    a = ZW'(85004756);
			5'd4:    a = ZW'(42667331);
			5'd5:    a = ZW'(21354465);
			5'd6:    a = ZW'(10679838);
			5'd7:    a = ZW'(5340245);
			5'd8:    a = ZW'(2670163);
			5'd9:    a = ZW'(1335087);
			5'd10:   a = ZW'(667544);
			5'd11:   a = ZW'(333772);
			5'd12:   a = ZW'(166886);
			5'd13:   a = ZW'(83443);
			5'd14:   a = ZW'(41722);
			5'd15:   a = ZW'(20861);
			5'd16:   a = ZW'(10430);
			5'd17:   a = ZW'(5215);
			5'd18:   a = ZW'(2608);
			5'd19:   a = ZW'(1304);
			5'd20:   a = ZW'(652);
			5'd21:   a = ZW'(326);
			5'd22:   a = ZW'(163);
			5'd23:   a = ZW'(81);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> design/rotary_position_rotator_unit.sv
// Top level of the rotary position rotator: front end, a row of CORDIC cells, back end.
// Depends on rpr_pkg, rpr_front, rpr_cell and rpr_back.
//
//  channel  signals                            payload     beat
//  item     item_valid, item_ready, item        in_beat_t   load entry or rotate pairs
//  result   result_valid, result_ready, result  out_beat_t  one per rotate beat
//
// One item enters per cycle while item_ready is high. A rotate beat passes
// 2 + CORDIC_STAGES + 3 registers (21 at 16 stages): table read, phase multiply,
// one per CORDIC cell, unfold, products, round and saturate. A load beat writes the
// table at the edge that takes it and gives no result. Reset clears only the valid bits;
// table entries hold nothing until loaded.
// Every stage holds while its successor is full and stalled; bubbles close up,
// so item_ready drops only when the whole row is full behind a stalled result.
module rotary_position_rotator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rpr_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output rpr_pkg::out_beat_t result
);

	logic          link_valid [rpr_pkg::CORDIC_STAGES+1];
	logic          link_ready [rpr_pkg::CORDIC_STAGES+1];
	rpr_pkg::rot_t link_data  [rpr_pkg::CORDIC_STAGES+1];

	rpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.dn_valid   (link_valid[0]),
		.dn_ready   (link_ready[0]),
		.dn_data    (link_data[0])
	);

	// Row of rotation cells, one per CORDIC step
	for (genvar g = 0; g < rpr_pkg::CORDIC_STAGES; g++) begin : g_cell
		rpr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage    (rpr_pkg::STAGE_W'(g)),
			.up_valid (link_valid[g]),
			.up_ready (link_ready[g]),
			.up_data  (link_data[g]),
			.dn_valid (link_valid[g+1]),
			.dn_ready (link_ready[g+1]),
			.dn_data  (link_data[g+1])
		);
	end

	rpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (link_valid[rpr_pkg::CORDIC_STAGES]),
		.up_ready     (link_ready[rpr_pkg::CORDIC_STAGES]),
		.up_data      (link_data[rpr_pkg::CORDIC_STAGES]),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> design/rpr_front.sv
// Front end: frequency table memory, phase multiply and quadrant fold into the first CORDIC cell.
// Depends on rpr_pkg.
module rpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rpr_pkg::in_beat_t item,
	output logic              dn_valid,
	input  logic              dn_ready,
	output rpr_pkg::rot_t     dn_data
);

	logic [rpr_pkg::FREQ_W-1:0] freq_mem [rpr_pkg::TABLE_DEPTH];

	logic                        accept;
	logic                        hit;
	logic                        rdy_s1;
	logic                        rdy_s2;

	logic                        v_s1;
	logic [rpr_pkg::FREQ_W-1:0]  freq_s1;
	logic                        hit_s1;
	logic [rpr_pkg::POS_W-1:0]   pos_s1;
	rpr_pkg::vec_t               vec_s1;

	logic                        v_s2;
	logic [rpr_pkg::FREQ_W-1:0]  phase_s2;
	rpr_pkg::vec_t               vec_s2;

	logic [rpr_pkg::FREQ_W-1:0]  freq_use;
	logic [rpr_pkg::FREQ_W+rpr_pkg::POS_W-1:0] prod;
	logic [rpr_pkg::FREQ_W-1:0]  shifted;

	// Handshake: each stage takes a beat when empty or when it moves on
	assign rdy_s2     = !v_s2 || dn_ready;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item_ready = rdy_s1;
	assign accept     = item_valid && rdy_s1;
	assign hit        = 32'(item.pair_index) < rpr_pkg::PAIRS;

	// Write on load beats, read on rotate beats
	always_ff @(posedge clk) begin
		if (accept && item.func == rpr_pkg::FUNC_LOAD && hit) begin
			freq_mem[item.pair_index] <= item.freq_word;
		end
		if (accept && item.func == rpr_pkg::FUNC_ROTATE) begin
			freq_s1 <= freq_mem[item.pair_index];
			hit_s1  <= hit;
			pos_s1  <= item.position;
			vec_s1  <= '{item.q_even, item.q_odd, item.k_even, item.k_odd};
		end
	end

	// Phase is the low word of position times frequency
	assign freq_use = hit_s1 ? freq_s1 : '0;
	assign prod     = (rpr_pkg::FREQ_W + rpr_pkg::POS_W)'(pos_s1)
			* (rpr_pkg::FREQ_W + rpr_pkg::POS_W)'(freq_use);

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			phase_s2 <= prod[rpr_pkg::FREQ_W-1:0];
			vec_s2   <= vec_s1;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept && item.func == rpr_pkg::FUNC_ROTATE;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Fold to the nearest quadrant and start the rotation there
	assign shifted = phase_s2 + 32'h2000_0000;

	always_comb begin
		dn_data      = '0;
		dn_data.quad = rpr_pkg::quad_t'(shifted[31:30]);
		dn_data.vec  = vec_s2;
		dn_data.x    = rpr_pkg::CORDIC_X0;
		dn_data.y    = '0;
		dn_data.z    = rpr_pkg::ZW'({3'b000, shifted[29:0]}) - rpr_pkg::ZW'(32'h2000_0000);
	end

	assign dn_valid = v_s2;

endmodule

>>> design/rpr_cell.sv
// One CORDIC rotation cell: holds x, y, z and the riding payload, steps once per beat.
// Depends on rpr_pkg.
module rpr_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rpr_pkg::STAGE_W-1:0]  stage,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  rpr_pkg::rot_t                up_data,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output rpr_pkg::rot_t                dn_data
);

	logic signed [rpr_pkg::CW-1:0] dx;
	logic signed [rpr_pkg::CW-1:0] dy;
	logic signed [rpr_pkg::ZW-1:0] ang;
	rpr_pkg::rot_t                 step;

	logic                          v_q;
	rpr_pkg::rot_t                 data_q;

	// Micro-rotation toward zero residual angle
	always_comb begin
		dx   = up_data.y >>> stage;
		dy   = up_data.x >>> stage;
		ang  = rpr_pkg::atan_turns(stage);
		step = up_data;
		if (!up_data.z[rpr_pkg::ZW-1]) begin
			step.x = up_data.x - dx;
			step.y = up_data.y + dy;
			step.z = up_data.z - ang;
		end else begin
			step.x = up_data.x + dx;
			step.y = up_data.y - dy;
			step.z = up_data.z + ang;
		end
	end

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	assign dn_valid = v_q;
	assign dn_data  = data_q;

endmodule

>>> design/rpr_back.sv
// Back end: quadrant unfold, the eight products, round, saturate and the output register.
// Depends on rpr_pkg.
module rpr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  rpr_pkg::rot_t      up_data,
	output logic               result_valid,
	input  logic               result_ready,
	output rpr_pkg::out_beat_t result
);

	localparam int PW     = rpr_pkg::DATA_W + rpr_pkg::CW;
	localparam int AW     = PW + 1;
	localparam int RSHIFT = 30;
	localparam int RW     = AW - RSHIFT;

	logic                          rdy_s1;
	logic                          rdy_s2;
	logic                          rdy_o;

	logic signed [rpr_pkg::CW-1:0] c;
	logic signed [rpr_pkg::CW-1:0] s;

	logic                          v_s1;
	logic signed [rpr_pkg::CW-1:0] c_s1;
	logic signed [rpr_pkg::CW-1:0] s_s1;
	rpr_pkg::vec_t                 vec_s1;

	logic                          v_s2;
	logic signed [PW-1:0]          qe_c_s2;
	logic signed [PW-1:0]          qo_s_s2;
	logic signed [PW-1:0]          qe_s_s2;
	logic signed [PW-1:0]          qo_c_s2;
	logic signed [PW-1:0]          ke_c_s2;
	logic signed [PW-1:0]          ko_s_s2;
	logic signed [PW-1:0]          ke_s_s2;
	logic signed [PW-1:0]          ko_c_s2;

	logic [rpr_pkg::DATA_W:0]      fin_qe;
	logic [rpr_pkg::DATA_W:0]      fin_qo;
	logic [rpr_pkg::DATA_W:0]      fin_ke;
	logic [rpr_pkg::DATA_W:0]      fin_ko;

	logic                          v_o_q;
	rpr_pkg::out_beat_t            result_q;

	// Round half up to Q3.12 and clip; top bit flags clipping
	function automatic logic [rpr_pkg::DATA_W:0] finish(input logic signed [AW-1:0] acc);
		logic signed [AW-1:0]     rnd;
		logic signed [RW-1:0]     r;
		logic [rpr_pkg::DATA_W:0] res;
		rnd = acc + AW'(2 ** (RSHIFT - 1));
		r   = RW'(rnd >>> RSHIFT);
		if (r > RW'(32767)) begin
			res = {1'b1, 16'h7FFF};
		end else if (r < RW'(-32768)) begin
			res = {1'b1, 16'h8000};
		end else begin
			res = {1'b0, r[rpr_pkg::DATA_W-1:0]};
		end
		return res;
	endfunction

	assign rdy_o    = !v_o_q || result_ready;
	assign rdy_s2   = !v_s2 || rdy_o;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// Unfold the quadrant into cosine and sine
	always_comb begin
		case (up_data.quad)
			rpr_pkg::QUAD_0: begin
				c = up_data.x;
				s = up_data.y;
			end
			rpr_pkg::QUAD_90: begin
				c = -up_data.y;
				s = up_data.x;
			end
			rpr_pkg::QUAD_180: begin
				c = -up_data.x;
				s = -up_data.y;
			end
			default: begin
				c = up_data.y;
				s = -up_data.x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s1) begin
			c_s1   <= c;
			s_s1   <= s;
			vec_s1 <= up_data.vec;
		end
	end

	// Products, one register deep
	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			qe_c_s2 <= PW'(vec_s1.q_even) * PW'(c_s1);
			qo_s_s2 <= PW'(vec_s1.q_odd) * PW'(s_s1);
			qe_s_s2 <= PW'(vec_s1.q_even) * PW'(s_s1);
			qo_c_s2 <= PW'(vec_s1.q_odd) * PW'(c_s1);
			ke_c_s2 <= PW'(vec_s1.k_even) * PW'(c_s1);
			ko_s_s2 <= PW'(vec_s1.k_odd) * PW'(s_s1);
			ke_s_s2 <= PW'(vec_s1.k_even) * PW'(s_s1);
			ko_c_s2 <= PW'(vec_s1.k_odd) * PW'(c_s1);
		end
	end

	// Combine, round and saturate into the output register
	assign fin_qe = finish(AW'(qe_c_s2) - AW'(qo_s_s2));
	assign fin_qo = finish(AW'(qe_s_s2) + AW'(qo_c_s2));
	assign fin_ke = finish(AW'(ke_c_s2) - AW'(ko_s_s2));
	assign fin_ko = finish(AW'(ke_s_s2) + AW'(ko_c_s2));

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_o) begin
			result_q.q_even_out <= fin_qe[rpr_pkg::DATA_W-1:0];
			result_q.q_odd_out  <= fin_qo[rpr_pkg::DATA_W-1:0];
			result_q.k_even_out <= fin_ke[rpr_pkg::DATA_W-1:0];
			result_q.k_odd_out  <= fin_ko[rpr_pkg::DATA_W-1:0];
			result_q.saturated  <= fin_qe[rpr_pkg::DATA_W] | fin_qo[rpr_pkg::DATA_W]
					| fin_ke[rpr_pkg::DATA_W] | fin_ko[rpr_pkg::DATA_W];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_o_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_o) begin
				v_o_q <= v_s2;
			end
		end
	end

	assign result_valid = v_o_q;
	assign result       = result_q;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for rotary_position_rotator_unit: directed table, then random beats.
// Depends on rpr_pkg for the beat types, sizes and item codes; carries its own rotation model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LIMIT_CYCLES   = 300000;
	localparam int  RANDOM_ITEMS   = 650;
	localparam int  DRAIN_CYCLES   = 2 + rpr_pkg::CORDIC_STAGES + 3 + 20;
	localparam int  ATAN_COUNT     = 24;
	localparam longint CORDIC_SEED = 652032874;

	// atan(2^-i) in 2^-32 turn
	localparam longint ATAN_TURNS [ATAN_COUNT] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304,
		652, 326, 163, 81
	};

	typedef struct {
		rpr_pkg::in_beat_t  beat;
		bit                 typed;
		rpr_pkg::out_beat_t want;
	} drill_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	rpr_pkg::in_beat_t  item;
	logic               result_valid;
	logic               result_ready;
	rpr_pkg::out_beat_t result;

	logic [rpr_pkg::FREQ_W-1:0] freq_table [rpr_pkg::TABLE_DEPTH];
	bit                         loaded [rpr_pkg::TABLE_DEPTH];
	logic [rpr_pkg::PAIR_W-1:0] loaded_list [$];
	rpr_pkg::out_beat_t         rotated_pairs_due [$];
	drill_t                     drills [$];
	int                         mismatches = 0;
	int                         send_idle = 14;
	int                         recv_idle = 45;
	int                         cycle_count = 0;

	rotary_position_rotator_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Round half up from scale 2^42 to Q3.12 and clip; bit 16 flags a clip
	function automatic logic [16:0] round_sat(longint acc);
		longint r;
		r = (acc + (longint'(1) <<< 29)) >>> 30;
		if (r > 32767)
			return {1'b1, 16'h7FFF};
		if (r < -32768)
			return {1'b1, 16'h8000};
		return {1'b0, r[15:0]};
	endfunction

	// Rotate both pairs by position * freq in units of 2^-32 turn
	function automatic rpr_pkg::out_beat_t rotate_pairs(logic [rpr_pkg::FREQ_W-1:0] freq,
			logic [rpr_pkg::POS_W-1:0] pos, rpr_pkg::in_beat_t b);
		logic [31:0]        phase;
		logic [31:0]        folded;
		logic [31:0]        resid;
		rpr_pkg::quad_t     quad;
		longint             x, y, z, dx, dy, c, s;
		longint             qe, qo, ke, ko;
		logic [16:0]        w [4];
		rpr_pkg::out_beat_t r;
		int                 i;
		phase  = pos * freq;
		folded = phase + 32'h2000_0000;
		quad   = rpr_pkg::quad_t'(folded[31:30]);
		resid  = phase - {folded[31:30], 30'b0};
		z = longint'($signed(resid));
		x = CORDIC_SEED;
		y = 0;
		// CORDIC in rotation mode
		for (i = 0; i < rpr_pkg::CORDIC_STAGES && i < ATAN_COUNT; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_TURNS[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_TURNS[i];
			end
		end
		// Unfold the quadrant
		case (quad)
			rpr_pkg::QUAD_0: begin
				c = x;
				s = y;
			end
			rpr_pkg::QUAD_90: begin
				c = -y;
				s = x;
			end
			rpr_pkg::QUAD_180: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
		qe = longint'($signed(b.q_even));
		qo = longint'($signed(b.q_odd));
		ke = longint'($signed(b.k_even));
		ko = longint'($signed(b.k_odd));
		w[0] = round_sat(qe * c - qo * s);
		w[1] = round_sat(qe * s + qo * c);
		w[2] = round_sat(ke * c - ko * s);
		w[3] = round_sat(ke * s + ko * c);
		r.q_even_out = w[0][15:0];
		r.q_odd_out  = w[1][15:0];
		r.k_even_out = w[2][15:0];
		r.k_odd_out  = w[3][15:0];
		r.saturated  = w[0][16] | w[1][16] | w[2][16] | w[3][16];
		return r;
	endfunction

	function automatic rpr_pkg::in_beat_t item_of(logic func, int idx, int pos,
			logic [rpr_pkg::FREQ_W-1:0] freq, int qe, int qo, int ke, int ko);
		rpr_pkg::in_beat_t b;
		b.func       = func;
		b.pair_index = rpr_pkg::PAIR_W'(idx);
		b.position   = rpr_pkg::POS_W'(pos);
		b.freq_word  = freq;
		b.q_even     = rpr_pkg::DATA_W'(qe);
		b.q_odd      = rpr_pkg::DATA_W'(qo);
		b.k_even     = rpr_pkg::DATA_W'(ke);
		b.k_odd      = rpr_pkg::DATA_W'(ko);
		return b;
	endfunction

	// Mostly random samples, now and then a corner value
	function automatic logic [rpr_pkg::DATA_W-1:0] random_sample();
		case ($urandom_range(15))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			default: return rpr_pkg::DATA_W'($urandom);
		endcase
	endfunction

	// Drive one item beat, wait for it to be taken, then update the model
	task automatic send_item(rpr_pkg::in_beat_t b, bit typed, rpr_pkg::out_beat_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= b;
		do @(posedge clk); while (!item_ready);
		if (b.func == rpr_pkg::FUNC_LOAD) begin
			if (b.pair_index < rpr_pkg::PAIRS) begin
				freq_table[b.pair_index] = b.freq_word;
				if (!loaded[b.pair_index]) begin
					loaded[b.pair_index] = 1'b1;
					loaded_list.push_back(b.pair_index);
				end
			end
		end else if (typed) begin
			rotated_pairs_due.push_back(want);
		end else begin
			rotated_pairs_due.push_back(rotate_pairs(
				(b.pair_index < rpr_pkg::PAIRS) ? freq_table[b.pair_index] : '0,
				b.position, b));
		end
	endtask

	task automatic compare_field(string name, logic signed [rpr_pkg::DATA_W-1:0] want,
			logic signed [rpr_pkg::DATA_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Check one result beat against the oldest rotation due
	task automatic check_result(rpr_pkg::out_beat_t got);
		rpr_pkg::out_beat_t want;
		if (rotated_pairs_due.size() == 0) begin
			mismatches++;
			$display("%0t: result beat with none due, expected nothing actual %h", $time, got);
		end else begin
			want = rotated_pairs_due.pop_front();
			compare_field("q_even_out", want.q_even_out, got.q_even_out);
			compare_field("q_odd_out", want.q_odd_out, got.q_odd_out);
			compare_field("k_even_out", want.k_even_out, got.k_even_out);
			compare_field("k_odd_out", want.k_odd_out, got.k_odd_out);
			compare_field("saturated", {15'b0, want.saturated}, {15'b0, got.saturated});
		end
	endtask

	// Result side: take beats, stall at random
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				check_result(result);
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Item side: reset, directed table, random beats, drain
	initial begin
		rpr_pkg::in_beat_t          b;
		logic [rpr_pkg::FREQ_W-1:0] freq;
		int                         k;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		for (k = 0; k < rpr_pkg::TABLE_DEPTH; k++) begin
			freq_table[k] = '0;
			loaded[k]     = 1'b0;
		end

		// Zero frequency and zero data give zero out at any position
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 0, 0, 32'h0000_0000, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 0, 0, 32'h0, 0, 0, 0, 0), 1'b1, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 0, 4095, 32'h0, 0, 0, 0, 0),
			1'b1, '0});
		// Largest frequency: phase just short of a full turn, and zero at position 0
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 63, 0, 32'hFFFF_FFFF, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 63, 4095, 32'h0,
			32767, 32767, -32768, -32768), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 63, 1, 32'h0,
			-32768, -32768, -32768, -32768), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 63, 0, 32'h0, -1, -1, 1, 1),
			1'b0, '0});
		// Quarter turn per position walks every quadrant
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 1, 0, 32'h4000_0000, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 1, 0, 32'h0,
			32767, -32768, 12345, -4096), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 1, 1, 32'h0,
			32767, -32768, 12345, -4096), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 1, 2, 32'h0,
			-32768, 32767, -4096, 12345), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 1, 3, 32'h0,
			-32768, -32768, 4096, 4096), 1'b0, '0});
		// Eighth turn sits on the quadrant rounding boundary; full-scale pairs clip; then about a third of a turn
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 2, 0, 32'h2000_0000, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 2, 1, 32'h0,
			-32768, -32768, -32768, -32768), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 2, 3, 32'h0,
			32767, 32767, 32767, 32767), 1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 3, 0, 32'h5555_5555, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 3, 4095, 32'h0,
			32767, -32768, 1, -1), 1'b0, '0});
		// Overwrite an entry: half turn negates, and negating the minimum clips
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 0, 0, 32'h8000_0000, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 0, 1, 32'h0,
			-32768, -32768, 32767, 0), 1'b0, '0});
		// Just below the quadrant boundary
		drills.push_back('{item_of(rpr_pkg::FUNC_LOAD, 32, 0, 32'h1FFF_FFFF, 0, 0, 0, 0),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 32, 1, 32'h0, 4096, 0, 0, 4096),
			1'b0, '0});
		drills.push_back('{item_of(rpr_pkg::FUNC_ROTATE, 32, 2, 32'h0, 0, 0, 0, 0),
			1'b1, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (drills[k])
			send_item(drills[k].beat, drills[k].typed, drills[k].want);

		// Random beats in three idling phases
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 3) begin
				send_idle = 45;
				recv_idle = 14;
			end else if (k == 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case ($urandom_range(9))
				0, 1, 2, 3: freq = $urandom;
				4, 5, 6:    freq = $urandom_range(0, 32'h0010_0000);
				7, 8:       freq = {4'($urandom_range(15)), 28'h0}
						+ 32'($urandom_range(4)) - 32'd2;
				default:    freq = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			endcase
			b.func       = ($urandom_range(99) < 15) ? rpr_pkg::FUNC_LOAD
					: rpr_pkg::FUNC_ROTATE;
			b.pair_index = rpr_pkg::PAIR_W'($urandom);
			b.position   = rpr_pkg::POS_W'($urandom);
			if ($urandom_range(15) == 0)
				b.position = $urandom_range(1) ? '1 : '0;
			b.freq_word  = freq;
			b.q_even     = random_sample();
			b.q_odd      = random_sample();
			b.k_even     = random_sample();
			b.k_odd      = random_sample();
			// Rotate only entries already loaded
			if (b.func == rpr_pkg::FUNC_ROTATE)
				b.pair_index = loaded_list[$urandom_range(loaded_list.size() - 1)];
			send_item(b, 1'b0, '0);
		end
		item_valid <= 1'b0;

		// Drain
		while (rotated_pairs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
design/rpr_pkg.sv
design/rpr_front.sv
design/rpr_cell.sv
design/rpr_back.sv
design/rotary_position_rotator_unit.sv
verif/testbench.sv
